[hw/rtl/keyed_shape_record_table_macros.svh]
// Assertion macros for the shape record table checker.
// Included by the checker file only; no other dependencies.
`ifndef KEYED_SHAPE_RECORD_TABLE_MACROS_SVH
`define KEYED_SHAPE_RECORD_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define KSRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define KSRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/ksrt_pkg.sv]
// Package for the shape record table: sizes, status and operation codes, record and item types.
// No dependencies.
package ksrt_pkg;
    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_RESET  = 2'd3;

    localparam logic [3:0] ST_FOUND      = 4'd0;
    localparam logic [3:0] ST_BAD_KIND   = 4'd1;
    localparam logic [3:0] ST_BAD_OFFSET = 4'd2;
    localparam logic [3:0] ST_BAD_EXTENT = 4'd3;
    localparam logic [3:0] ST_ADDED      = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND  = 4'd5;
    localparam logic [3:0] ST_REMOVED    = 4'd6;
    localparam logic [3:0] ST_RESET      = 4'd7;
    localparam logic [3:0] ST_FULL       = 4'd8;

    localparam logic [2:0] KIND_LIMIT = 3'd5;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  kind;
        logic [31:0] off_x;
        logic [31:0] off_y;
        logic [31:0] off_z;
        logic [31:0] ext_x;
        logic [31:0] ext_y;
        logic [31:0] ext_z;
        logic        sensor;
    } t_rec;

    // request item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] shape_id;
        logic [2:0]  shape_kind;
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] offset_z;
        logic [31:0] extent_x;
        logic [31:0] extent_y;
        logic [31:0] extent_z;
        logic        sensor_flag;
    } t_req_item;

    // result item
    typedef struct packed {
        logic        ok;
        logic [3:0]  status;
        logic [31:0] result_id;
        logic [5:0]  slot_index;
        logic [2:0]  out_kind;
        logic [31:0] out_offset_x;
        logic [31:0] out_offset_y;
        logic [31:0] out_offset_z;
        logic [31:0] out_extent_x;
        logic [31:0] out_extent_y;
        logic [31:0] out_extent_z;
        logic        out_sensor;
    } t_rsp_item;

    // control broadcast to each cell
    typedef struct packed {
        logic              wr;     // append the record at slot wr_slot
        logic              shift;  // cells at or above sh_slot take their upper neighbor
        logic [SLOT_W-1:0] wr_slot;
        logic [SLOT_W-1:0] sh_slot;
    } t_cell_ctl;

    function automatic logic is_finite(input logic [31:0] b);
        return b[30:23] != 8'hFF;
    endfunction

    function automatic logic is_pos(input logic [31:0] b);
        return !b[31] && (b[30:0] != 31'd0);
    endfunction
endpackage

[hw/rtl/ksrt_if.sv]
// Valid/ready channel interfaces for request and result items.
// Depends on ksrt_pkg for the item types.
interface ksrt_req_if;
    import ksrt_pkg::*;
    logic      valid;
    logic      ready;
    t_req_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ksrt_rsp_if;
    import ksrt_pkg::*;
    logic      valid;
    logic      ready;
    t_rsp_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/ksrt_cell.sv]
// One table slot: holds a record, compares its id, shifts down from its upper neighbor.
// Depends on ksrt_pkg.
module ksrt_cell (
    input  logic                      i_clk,
    input  logic [ksrt_pkg::SLOT_W-1:0] i_pos,
    input  ksrt_pkg::t_cell_ctl       i_ctl,
    input  ksrt_pkg::t_rec            i_new,
    input  ksrt_pkg::t_rec            i_up,
    input  logic [31:0]               i_key,
    output ksrt_pkg::t_rec            o_rec,
    output logic                      o_hit
);
    import ksrt_pkg::*;
    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_ctl.wr_slot == i_pos) begin
            r_rec <= i_new;
        end else if (i_ctl.shift && i_pos >= i_ctl.sh_slot) begin
            r_rec <= i_up;
        end
    end

    assign o_rec = r_rec;
    assign o_hit = (r_rec.id == i_key);
endmodule

[hw/rtl/keyed_shape_record_table.sv]
// Top level of the shape record table: a chain of slot cells plus a small controller.
// Depends on ksrt_pkg, ksrt_if and ksrt_cell.
//
//  channel  | dir | payload
//  i_req    | in  | kind, shape_id, shape_kind, offset_x..z, extent_x..z, sensor_flag
//  o_rsp    | out | ok, status, result_id, slot_index, out_kind, out_offset/extent, out_sensor
//
// An item is registered at the accept edge, and the cells compare it against
// their ids; in execute, once the output register is free, the lowest hit is
// picked (priority encode over the valid slots), the cells are updated and the
// output register is loaded; a remove shifts every later cell down with them.
// Input is ready whenever no item is executing, so the next item is taken
// while the previous result waits; an item only stalls in execute while the
// output register still holds an unaccepted result.
// Reset (i_rst_n low, synchronous) empties the table and sets next id to 1;
// cell contents are not cleared.
module keyed_shape_record_table (
    input  logic i_clk,
    input  logic i_rst_n,
    ksrt_req_if.sink   i_req,
    ksrt_rsp_if.source o_rsp
);
    import ksrt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state            r_state;
    t_req_item         r_req;
    logic [CNT_W-1:0]  r_count;
    logic [31:0]       r_next_id;
    logic              r_ovalid;
    logic              r_ok;
    logic [3:0]        r_status;
    logic [31:0]       r_rid;
    logic [5:0]        r_slot;
    t_rec              r_orec;

    logic              n_ok;
    logic [3:0]        n_status;
    logic [31:0]       n_rid;
    logic [5:0]        n_slot;
    t_rec              n_orec;

    t_rec              w_rec [CAPACITY];
    logic [CAPACITY-1:0] w_hit;
    t_cell_ctl         w_ctl;
    t_rec              w_new;

    logic              w_found;
    logic [SLOT_W-1:0] w_fslot;
    logic              w_accept;
    logic              w_done;
    t_req_item         w_in;

    assign w_in = i_req.data;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept = i_req.valid && i_req.ready;
    // execute only once the output register is free or being emptied
    assign w_done = (r_state == S_EXEC) && (!r_ovalid || o_rsp.ready);

    // lowest valid hit; id zero never matches
    always_comb begin
        w_found = 1'b0;
        w_fslot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_hit[i] && (CNT_W'(i) < r_count) && r_req.shape_id != 32'd0) begin
                w_found = 1'b1;
                w_fslot = SLOT_W'(i);
            end
        end
    end

    logic w_add_ok;
    logic [3:0] w_add_st;
    always_comb begin
        w_add_ok = 1'b0;
        if (r_req.shape_kind >= KIND_LIMIT) begin
            w_add_st = ST_BAD_KIND;
        end else if (!(is_finite(r_req.offset_x) && is_finite(r_req.offset_y)
                       && is_finite(r_req.offset_z))) begin
            w_add_st = ST_BAD_OFFSET;
        end else if (!(is_finite(r_req.extent_x) && is_pos(r_req.extent_x)
                       && is_finite(r_req.extent_y) && is_pos(r_req.extent_y)
                       && is_finite(r_req.extent_z) && is_pos(r_req.extent_z))) begin
            w_add_st = ST_BAD_EXTENT;
        end else if (r_count == CNT_W'(CAPACITY)) begin
            w_add_st = ST_FULL;
        end else begin
            w_add_st = ST_ADDED;
            w_add_ok = 1'b1;
        end
    end

    always_comb begin
        w_new = '{id: r_next_id, kind: r_req.shape_kind,
                  off_x: r_req.offset_x, off_y: r_req.offset_y, off_z: r_req.offset_z,
                  ext_x: r_req.extent_x, ext_y: r_req.extent_y, ext_z: r_req.extent_z,
                  sensor: r_req.sensor_flag};
        w_ctl.wr = w_done && r_req.kind == OP_ADD && w_add_ok;
        w_ctl.wr_slot = r_count[SLOT_W-1:0];
        w_ctl.shift = w_done && r_req.kind == OP_REMOVE && w_found;
        w_ctl.sh_slot = w_fslot;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_rec w_up;
        if (g == CAPACITY - 1) begin : g_top
            assign w_up = w_rec[g];
        end else begin : g_mid
            assign w_up = w_rec[g+1];
        end
        ksrt_cell u_cell (
            .i_clk (i_clk),
            .i_pos (SLOT_W'(g)),
            .i_ctl (w_ctl),
            .i_new (w_new),
            .i_up  (w_up),
            .i_key (r_req.shape_id),
            .o_rec (w_rec[g]),
            .o_hit (w_hit[g])
        );
    end

    // result of the executing item; not found unless a branch says otherwise
    always_comb begin
        n_ok     = 1'b0;
        n_status = ST_NOT_FOUND;
        n_rid    = r_req.shape_id;
        n_slot   = '0;
        n_orec   = '0;
        case (r_req.kind)
            OP_ADD: begin
                n_ok     = w_add_ok;
                n_status = w_add_st;
                n_rid    = w_add_ok ? r_next_id : 32'd0;
                if (w_add_ok) begin
                    n_slot = 6'(r_count[SLOT_W-1:0]);
                    n_orec = w_new;
                end
            end
            OP_RESET: begin
                n_ok     = 1'b1;
                n_status = ST_RESET;
                n_rid    = 32'd0;
            end
            default: begin
                if (w_found) begin
                    n_ok     = 1'b1;
                    n_status = (r_req.kind == OP_READ) ? ST_FOUND : ST_REMOVED;
                    n_slot   = 6'(w_fslot);
                    n_orec   = w_rec[w_fslot];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= w_in;
        end
        if (w_done) begin
            r_ok     <= n_ok;
            r_status <= n_status;
            r_rid    <= n_rid;
            r_slot   <= n_slot;
            r_orec   <= n_orec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_next_id <= 32'd1;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_done) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_done) begin
                        r_state <= S_IDLE;
                        if (w_ctl.wr) begin
                            r_count   <= r_count + CNT_W'(1);
                            r_next_id <= r_next_id + 32'd1;
                        end else if (w_ctl.shift) begin
                            r_count <= r_count - CNT_W'(1);
                        end else if (r_req.kind == OP_RESET) begin
                            r_count   <= '0;
                            r_next_id <= 32'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data.ok = r_ok;
    assign o_rsp.data.status = r_status;
    assign o_rsp.data.result_id = r_rid;
    assign o_rsp.data.slot_index = r_slot;
    assign o_rsp.data.out_kind = r_orec.kind;
    assign o_rsp.data.out_offset_x = r_orec.off_x;
    assign o_rsp.data.out_offset_y = r_orec.off_y;
    assign o_rsp.data.out_offset_z = r_orec.off_z;
    assign o_rsp.data.out_extent_x = r_orec.ext_x;
    assign o_rsp.data.out_extent_y = r_orec.ext_y;
    assign o_rsp.data.out_extent_z = r_orec.ext_z;
    assign o_rsp.data.out_sensor = r_orec.sensor;
endmodule

[hw/rtl/ksrt_checker.sv]
// Port-level checker for the shape record table, bound to the top level.
// Depends on ksrt_pkg, the macros header and the top-level port names.
`include "keyed_shape_record_table_macros.svh"
module ksrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_v,
    input logic       in_r,
    input logic       out_v,
    input logic       out_r,
    input logic       ok,
    input logic [3:0] st
);
    import ksrt_pkg::*;

    `KSRT_ASSERT_IMP(a_ok_status, i_clk, i_rst_n, out_v && ok, st == ST_FOUND || st == ST_ADDED || st == ST_REMOVED || st == ST_RESET)
    `KSRT_ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, in_v && in_r, !in_r)
    `KSRT_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, out_v && !out_r, out_v && $stable(st))
endmodule

bind keyed_shape_record_table ksrt_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .in_v    (i_req.valid),
    .in_r    (i_req.ready),
    .out_v   (o_rsp.valid),
    .out_r   (o_rsp.ready),
    .ok      (o_rsp.data.ok),
    .st      (o_rsp.data.status)
);

[tb/tb.sv]
// Self-checking testbench for keyed_shape_record_table: table ops vs. an in-bench predictor.
// Depends on ksrt_pkg, ksrt_if and the keyed_shape_record_table RTL.
`timescale 1ns / 100ps

module tb;
    import ksrt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ksrt_req_if req_ch ();
    ksrt_rsp_if rsp_ch ();

    keyed_shape_record_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow table, updated at each accepted item
    t_rec        shadow_tbl [CAPACITY];
    int          shadow_cnt;
    logic [31:0] shadow_next_id;

    t_req_item pend_q[$];
    t_rsp_item expected_rsp_q[$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      hold_go = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_left = 0;
    int        fail_cnt = 0;
    int        cycle_cnt = 0;

    function automatic logic fin(input logic [31:0] b);
        return b[30:23] != 8'hFF;
    endfunction

    function automatic logic pos(input logic [31:0] b);
        return !b[31] && (b[30:0] != 31'd0);
    endfunction

    function automatic t_rsp_item rec_fields(input t_rsp_item r, input int slot);
        t_rsp_item o;
        o = r;
        o.slot_index   = slot[5:0];
        o.out_kind     = shadow_tbl[slot].kind;
        o.out_offset_x = shadow_tbl[slot].off_x;
        o.out_offset_y = shadow_tbl[slot].off_y;
        o.out_offset_z = shadow_tbl[slot].off_z;
        o.out_extent_x = shadow_tbl[slot].ext_x;
        o.out_extent_y = shadow_tbl[slot].ext_y;
        o.out_extent_z = shadow_tbl[slot].ext_z;
        o.out_sensor   = shadow_tbl[slot].sensor;
        return o;
    endfunction

    // Computes the response of one item and applies it to the shadow table.
    function automatic t_rsp_item table_response(input t_req_item q);
        t_rsp_item r;
        int slot;
        r = '0;
        slot = -1;
        case (q.kind)
            OP_ADD: begin
                if (q.shape_kind >= KIND_LIMIT) begin
                    r.status = ST_BAD_KIND;
                end else if (!fin(q.offset_x) || !fin(q.offset_y) || !fin(q.offset_z)) begin
                    r.status = ST_BAD_OFFSET;
                end else if (!fin(q.extent_x) || !pos(q.extent_x) || !fin(q.extent_y) ||
                             !pos(q.extent_y) || !fin(q.extent_z) || !pos(q.extent_z)) begin
                    r.status = ST_BAD_EXTENT;
                end else if (shadow_cnt >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_tbl[shadow_cnt] = '{shadow_next_id, q.shape_kind, q.offset_x,
                        q.offset_y, q.offset_z, q.extent_x, q.extent_y, q.extent_z,
                        q.sensor_flag};
                    r.ok = 1'b1;
                    r.status = ST_ADDED;
                    r.result_id = shadow_next_id;
                    r = rec_fields(r, shadow_cnt);
                    shadow_cnt++;
                    shadow_next_id++;
                end
            end
            OP_RESET: begin
                shadow_cnt = 0;
                shadow_next_id = 32'd1;
                r.ok = 1'b1;
                r.status = ST_RESET;
            end
            default: begin
                r.result_id = q.shape_id;
                if (q.shape_id != 32'd0)
                    for (int i = shadow_cnt - 1; i >= 0; i--)
                        if (shadow_tbl[i].id == q.shape_id) slot = i;
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.ok = 1'b1;
                    r = rec_fields(r, slot);
                    if (q.kind == OP_READ) begin
                        r.status = ST_FOUND;
                    end else begin
                        r.status = ST_REMOVED;
                        for (int i = slot; i + 1 < shadow_cnt; i++)
                            shadow_tbl[i] = shadow_tbl[i + 1];
                        shadow_cnt--;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // float bit pattern: mostly finite normals, plus specials
    function automatic logic [31:0] rand_float(input int special_pct);
        logic [31:0] b;
        b = $urandom;
        if ($urandom_range(99) < special_pct) begin
            case ($urandom_range(5))
                0: b[30:23] = 8'hFF;                 // inf or nan
                1: b[30:0] = 31'd0;                  // +/- zero
                2: b[30:23] = 8'h00;                 // subnormal
                3: b[31] = 1'b1;                     // negative
                4: b = 32'h7F7FFFFF;
                default: b = 32'hFF7FFFFF;
            endcase
        end else begin
            if (b[30:23] == 8'hFF) b[30] = 1'b0;
            b[31] = (special_pct == 0) ? b[31] : 1'b0;
        end
        return b;
    endfunction

    function automatic t_req_item make_add(input logic [2:0] k, input logic [31:0] o,
                                           input logic [31:0] e);
        t_req_item q;
        q = '{OP_ADD, $urandom, k, o, o, o, e, e, e, 1'($urandom_range(1))};
        return q;
    endfunction

    function automatic t_req_item rand_item();
        t_req_item q;
        int roll;
        int pick;
        roll = $urandom_range(99);
        q = '{OP_ADD, $urandom, 3'($urandom_range(4)), rand_float(0), rand_float(0),
              rand_float(0), 32'h3F800000, 32'h3F800000, 32'h3F800000,
              1'($urandom_range(1))};
        q.extent_x = rand_float(4);
        q.extent_y = rand_float(4);
        q.extent_z = rand_float(4);
        q.extent_x[31] = ($urandom_range(99) < 3);
        if (roll < 8) begin
            q.shape_kind = 3'($urandom_range(7));
            q.offset_x = rand_float(30);
            q.extent_y = rand_float(30);
        end else if (roll < 55) begin
            // add, mostly well-formed; extents may still be invalid
        end else if (roll < 93) begin
            q.kind = (roll < 75) ? OP_READ : OP_REMOVE;
            pick = $urandom_range(9);
            if (pick < 7 && shadow_cnt > 0)
                q.shape_id = shadow_tbl[$urandom_range(shadow_cnt - 1)].id;
            else if (pick < 9)
                q.shape_id = $urandom_range(shadow_next_id + 2);
        end else if (roll < 95) begin
            q.kind = OP_RESET;
        end else begin
            q.kind = 2'($urandom_range(3));
        end
        return q;
    endfunction

    task automatic queue_item(input t_req_item q);
        pend_q = {pend_q, q};
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        shadow_cnt = 0;
        shadow_next_id = 32'd1;
    end

    // driver: present the next pending item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_ch.data  <= pend_q.pop_front();
                req_ch.valid <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on accept, compare on response
    always @(posedge i_clk) begin
        t_rsp_item e;
        t_rsp_item a;
        if (i_rst_n && req_ch.valid && req_ch.ready)
            expected_rsp_q = {expected_rsp_q, table_response(req_ch.data)};
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            a = rsp_ch.data;
            if (expected_rsp_q.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual %h", $time, a);
                fail_cnt++;
            end else begin
                e = expected_rsp_q.pop_front();
                check_field("ok", 32'(e.ok), 32'(a.ok));
                check_field("status", 32'(e.status), 32'(a.status));
                check_field("result_id", e.result_id, a.result_id);
                check_field("slot_index", 32'(e.slot_index), 32'(a.slot_index));
                check_field("out_kind", 32'(e.out_kind), 32'(a.out_kind));
                check_field("out_offset_x", e.out_offset_x, a.out_offset_x);
                check_field("out_offset_y", e.out_offset_y, a.out_offset_y);
                check_field("out_offset_z", e.out_offset_z, a.out_offset_z);
                check_field("out_extent_x", e.out_extent_x, a.out_extent_x);
                check_field("out_extent_y", e.out_extent_y, a.out_extent_y);
                check_field("out_extent_z", e.out_extent_z, a.out_extent_z);
                check_field("out_sensor", 32'(e.out_sensor), 32'(a.out_sensor));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_req_item q;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, each op, each validation failure
        queue_item(make_add(3'd4, 32'hFF7FFFFF, 32'h00000001));
        queue_item(make_add(3'd0, 32'h00000000, 32'h7F7FFFFF));
        queue_item(make_add(3'd2, 32'h80000000, 32'h3F800000));
        queue_item(make_add(3'd5, 32'h0, 32'h3F800000));
        queue_item(make_add(3'd7, 32'h7F800000, 32'h0));
        q = make_add(3'd1, 32'h0, 32'h3F800000); q.offset_z = 32'h7FC00000;
        queue_item(q);
        q = make_add(3'd1, 32'h0, 32'h3F800000); q.offset_y = 32'hFF800000;
        queue_item(q);
        q = make_add(3'd1, 32'h7F800000, 32'h0);
        queue_item(q);
        queue_item(make_add(3'd1, 32'h0, 32'h00000000));
        queue_item(make_add(3'd1, 32'h0, 32'h80000000));
        queue_item(make_add(3'd1, 32'h0, 32'hBF800000));
        q = make_add(3'd1, 32'h0, 32'h3F800000); q.extent_z = 32'h7F800000;
        queue_item(q);
        queue_item('{OP_READ, 32'd0, 3'd0, 0, 0, 0, 0, 0, 0, 1'b0});
        queue_item('{OP_READ, 32'd2, 3'd7, 0, 0, 0, 0, 0, 0, 1'b1});
        queue_item('{OP_READ, 32'hFFFFFFFF, 3'd0, 0, 0, 0, 0, 0, 0, 1'b0});
        queue_item('{OP_REMOVE, 32'd2, 3'd0, 0, 0, 0, 0, 0, 0, 1'b0});
        queue_item('{OP_READ, 32'd3, 3'd0, 0, 0, 0, 0, 0, 0, 1'b0});
        queue_item('{OP_REMOVE, 32'd2, 3'd0, 0, 0, 0, 0, 0, 0, 1'b0});
        queue_item('{OP_REMOVE, 32'd0, 3'd0, 0, 0, 0, 0, 0, 0, 1'b0});
        queue_item('{OP_RESET, 32'hFFFFFFFF, 3'd7, '1, '1, '1, '1, '1, '1, 1'b1});
        queue_item('{OP_READ, 32'd1, 3'd0, 0, 0, 0, 0, 0, 0, 1'b0});
        queue_item(make_add(3'd3, 32'h3F000000, 32'h40000000));
        wait (pend_q.size() == 0 && !req_ch.valid && expected_rsp_q.size() == 0);

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 17 : 0;
            recv_stall_pct = (ph == 2) ? 53 : (ph == 3) ? 17 : 0;
            for (int n = 0; n < 235; n++) begin
                // predictor state lags a little; good enough to pick live ids
                queue_item(rand_item());
                if (n % 8 == 7) wait (pend_q.size() < 4);
            end
            if (ph == 0) begin
                hold_go = 1'b1;
                for (int n = 0; n < 40; n++) queue_item(rand_item());
            end
            wait (pend_q.size() == 0);
        end

        wait (pend_q.size() == 0 && !req_ch.valid && expected_rsp_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && expected_rsp_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ksrt_pkg.sv
hw/rtl/ksrt_if.sv
hw/rtl/ksrt_cell.sv
hw/rtl/keyed_shape_record_table.sv
hw/rtl/ksrt_checker.sv
tb/tb.sv
